// ===== hw/rtl/skrf_pkg.sv =====
// Package for the spike key row fetch sequencer.
// Holds the command and result codes, the payload structs and the table entry type.
// No dependencies.
`default_nettype none

package skrf_pkg;

  // Input commands.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;
  localparam logic [1:0] KIND_OVF   = 2'd3;

  localparam logic [31:0] ID_END      = 32'hFFFF_FFFF;
  localparam logic [15:0] OVF_MAX     = 16'hFFFF;
  localparam logic [10:0] HDR_WORDS   = 11'd3;
  localparam int          MAX_RESULTS = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [3:0]  entry_index;
    logic [31:0] entry_mask;
    logic [31:0] entry_id;
    logic [31:0] entry_base;
    logic [9:0]  entry_row_words;
  } skrf_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        slot;
    logic [31:0] row_address;
    logic [12:0] length_bytes;
    logic [9:0]  row_words;
    logic [31:0] dropped_key;
    logic [15:0] overflow_count;
    logic        last;
  } skrf_out_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] id;
    logic [31:0] base;
    logic [9:0]  row_words;
  } skrf_entry_t;

  // Row fetch length in bytes: payload words plus the three-word header.
  function automatic logic [12:0] row_len(input logic [9:0] rw);
    logic [10:0] words;
    words = {1'b0, rw} + HDR_WORDS;
    return {words, 2'b00};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spike_key_row_fetch_sequencer.sv =====
// Flow: a ring overflow or row ready result is staged in S_EMIT and registered on the output
// once the output register is free. Each popped key is read in S_FEED and walked through the
// table in S_WALK one entry per cycle; a miss goes to S_EMIT as a drop, a hit through S_MUL.
// Throughput: one transaction at a time; in_ready is low until all its results are issued.
// Results stall on out_ready.
// Reset: synchronous, active low; clears pointers, flags, counters and table valid bits at once.
`default_nettype none

module spike_key_row_fetch_sequencer import skrf_pkg::*; #(
  parameter int RING_DEPTH  = 32,
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire skrf_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output skrf_out_t      out_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(RING_DEPTH - 1);
  localparam logic [IW-1:0] IDX_LAST  = IW'(TABLE_DEPTH - 1);
  localparam logic [8:0]    TD9       = 9'(TABLE_DEPTH);
  localparam logic [NW-1:0] N_MAX     = NW'(MAX_RESULTS);
  localparam logic [NW-1:0] N_LASTONE = NW'(MAX_RESULTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FEED = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Control state.
  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          busy_r, busy_nxt;
  logic          paused_r, paused_nxt;
  logic          slot_sel_r, slot_sel_nxt;
  logic [9:0]    slot_rw_r [2];
  logic          slot_rw_we;
  logic [15:0]   ovf_cnt_r, ovf_cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]    em_kind_r, em_kind_nxt;
  logic          em_last_r, em_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload state.
  logic [31:0]   ring_mem_r [RING_DEPTH];
  logic [31:0]   ring_q_r;
  logic [31:0]   ovf_key_r, ovf_key_nxt;
  logic [31:0]   prod_r, prod_nxt;
  skrf_out_t     out_data_r, out_data_nxt;

  // Combinational helpers.
  logic          in_acc;
  logic          ring_empty;
  logic          ring_full;
  logic          ring_we;
  logic          ring_re;
  logic          out_free;
  logic          tbl_we;
  logic [IW-1:0] tbl_wr_addr;
  skrf_entry_t   tbl_wr_entry;
  logic          tbl_re;
  logic [IW-1:0] tbl_rd_addr;
  skrf_entry_t   ent;
  logic [31:0]   mul_full;
  logic          hit;
  skrf_out_t     emit_data;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign ring_empty = (rd_ptr_r == wr_ptr_r);
  assign ring_full  = (ptr_inc(wr_ptr_r) == rd_ptr_r);
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign tbl_we       = in_acc && (in_data.cmd == CMD_LOAD) && ({5'b0, in_data.entry_index} < TD9);
  assign tbl_wr_addr  = IW'({{IW{1'b0}}, in_data.entry_index});
  assign tbl_wr_entry = '{mask: in_data.entry_mask, id: in_data.entry_id,
                          base: in_data.entry_base, row_words: in_data.entry_row_words};

  skrf_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_addr  (tbl_wr_addr),
    .wr_entry (tbl_wr_entry),
    .rd_en    (tbl_re),
    .rd_addr  (tbl_rd_addr),
    .rd_entry (ent)
  );

  // The walk compares the popped key against one table entry per cycle.
  // The row offset wraps at 32 bits, so only the low product bits are kept.
  assign hit      = ((ent.mask & ring_q_r) == ent.id);
  assign mul_full = 32'((ring_q_r & ~ent.mask) * row_len(ent.row_words));

  // Result word for the pending emission.
  always_comb begin
    emit_data = '0;
    emit_data.kind = em_kind_r;
    emit_data.overflow_count = ovf_cnt_r;
    case (em_kind_r)
      KIND_FETCH: begin
        emit_data.slot         = slot_sel_r;
        emit_data.row_address  = ent.base + prod_r;
        emit_data.length_bytes = row_len(ent.row_words);
        emit_data.row_words    = ent.row_words;
        emit_data.last         = 1'b1;
      end
      KIND_READY: begin
        emit_data.slot         = ~slot_sel_r;
        emit_data.length_bytes = row_len(slot_rw_r[~slot_sel_r]);
        emit_data.row_words    = slot_rw_r[~slot_sel_r];
        emit_data.last         = ring_empty;
      end
      KIND_DROP: begin
        emit_data.dropped_key = ring_q_r;
        emit_data.last        = em_last_r;
      end
      default: begin
        emit_data.dropped_key = ovf_key_r;
        emit_data.last        = 1'b1;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    busy_nxt      = busy_r;
    paused_nxt    = paused_r;
    slot_sel_nxt  = slot_sel_r;
    slot_rw_we    = 1'b0;
    ovf_cnt_nxt   = ovf_cnt_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    em_kind_nxt   = em_kind_r;
    em_last_nxt   = em_last_r;
    ovf_key_nxt   = ovf_key_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    tbl_re        = 1'b0;
    tbl_rd_addr   = idx_r + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          n_nxt = '0;
          case (in_data.cmd)
            CMD_KEY: begin
              if (ring_full) begin
                if (ovf_cnt_r != OVF_MAX) begin
                  ovf_cnt_nxt = ovf_cnt_r + 1'b1;
                end
                ovf_key_nxt = in_data.key;
                em_kind_nxt = KIND_OVF;
                state_nxt   = S_EMIT;
              end else begin
                ring_we    = 1'b1;
                wr_ptr_nxt = ptr_inc(wr_ptr_r);
                if (!busy_r) begin
                  busy_nxt  = 1'b1;
                  state_nxt = S_FEED;
                end else if (paused_r) begin
                  state_nxt = S_FEED;
                end
              end
            end
            CMD_DONE: begin
              if (busy_r && paused_r) begin
                state_nxt = S_FEED;
              end else if (busy_r) begin
                em_kind_nxt = KIND_READY;
                state_nxt   = S_EMIT;
              end
            end
            default: begin
              // Table loads are written straight from the port; cmd 3 is ignored.
            end
          endcase
        end
      end
      S_FEED: begin
        if (ring_empty) begin
          busy_nxt   = 1'b0;
          paused_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end else if (n_r >= N_MAX) begin
          paused_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ring_re     = 1'b1;
          rd_ptr_nxt  = ptr_inc(rd_ptr_r);
          tbl_re      = 1'b1;
          tbl_rd_addr = '0;
          idx_nxt     = '0;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (ent.id != ID_END && hit) begin
          state_nxt = S_MUL;
        end else if (ent.id == ID_END || idx_r == IDX_LAST) begin
          em_kind_nxt = KIND_DROP;
          em_last_nxt = ring_empty || (n_r >= N_LASTONE);
          state_nxt   = S_EMIT;
        end else begin
          tbl_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_full;
        em_kind_nxt = KIND_FETCH;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_data;
          n_nxt         = n_r + 1'b1;
          case (em_kind_r)
            KIND_FETCH: begin
              slot_rw_we   = 1'b1;
              slot_sel_nxt = ~slot_sel_r;
              paused_nxt   = 1'b0;
              state_nxt    = S_IDLE;
            end
            KIND_OVF: begin
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_FEED;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      busy_r       <= 1'b0;
      paused_r     <= 1'b0;
      slot_sel_r   <= 1'b0;
      slot_rw_r[0] <= '0;
      slot_rw_r[1] <= '0;
      ovf_cnt_r    <= '0;
      n_r          <= '0;
      idx_r        <= '0;
      em_kind_r    <= KIND_FETCH;
      em_last_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      busy_r      <= busy_nxt;
      paused_r    <= paused_nxt;
      slot_sel_r  <= slot_sel_nxt;
      if (slot_rw_we) begin
        slot_rw_r[slot_sel_r] <= ent.row_words;
      end
      ovf_cnt_r   <= ovf_cnt_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      em_kind_r   <= em_kind_nxt;
      em_last_r   <= em_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Key ring memory and payload registers.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem_r[wr_ptr_r] <= in_data.key;
    end
    if (ring_re) begin
      ring_q_r <= ring_mem_r[rd_ptr_r];
    end
    ovf_key_r  <= ovf_key_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // An idle sequencer always leaves the ring drained.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (rd_ptr_r == wr_ptr_r))
    else $error("sequencer idle with keys left in the ring");

  // A paused scan keeps the fetch slot claimed.
  a_pause_busy: assert property (@(posedge clk) disable iff (!rst_n)
    paused_r |-> busy_r)
    else $error("scan paused while no fetch is claimed");

  // A key written into the ring leaves it non-empty.
  a_ring_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_KEY && !ring_full) |=> (rd_ptr_r != wr_ptr_r))
    else $error("ring write lost");

  // Issuing a fetch request toggles the double-buffer slot.
  a_slot_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && em_kind_r == KIND_FETCH)
      |=> (slot_sel_r != $past(slot_sel_r)))
    else $error("slot select did not toggle on fetch");

  // One transaction never produces more results than the budget.
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_MAX)
    else $error("result budget exceeded");

endmodule

`default_nettype wire

// ===== hw/rtl/skrf_table.sv =====
// Routing table storage for the spike key row fetch sequencer.
// One write port, one registered read port, per-entry valid bits; uses skrf_pkg.
`default_nettype none

module skrf_table import skrf_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire skrf_entry_t wr_entry,
  input  wire logic        rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output skrf_entry_t      rd_entry
);

  skrf_entry_t             mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  vld_r;
  skrf_entry_t             rd_q_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as the empty-table value.
  always_comb begin
    if (rd_vld_r) begin
      rd_entry = rd_q_r;
    end else begin
      rd_entry = '{mask: '0, id: ID_END, base: '0, row_words: '0};
    end
  end

endmodule

`default_nettype wire

// ===== tb/spike_key_row_fetch_sequencer_test.sv =====
// Self-checking testbench for the spike key row fetch sequencer.
// Depends on skrf_pkg and spike_key_row_fetch_sequencer; a directed table runs first, then
// random traffic, and every result is compared with a cycle-free model or a hand-typed result.
module spike_key_row_fetch_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skrf_pkg::*;

  // The block is built with its default sizes; the model uses the same ones.
  localparam int RING_SLOTS    = 32;
  localparam int TABLE_ENTRIES = 16;

  // The package has no name for the fourth command code, which the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 74;
  localparam int CYCLE_LIMIT   = 400000;
  // Extra idle time after the last owed result, so that any straggler still shows up.
  localparam int SETTLE_CYCLES = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  skrf_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  skrf_out_t out_data;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  spike_key_row_fetch_sequencer #(
    .RING_DEPTH (RING_SLOTS),
    .TABLE_DEPTH(TABLE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Model of the sequencer. It keeps its own copy of the key ring, the routing
  // table and the double-buffer bookkeeping, and is stepped once per accepted
  // transaction. The results of one step land in step_events; the ones still
  // owed by the block wait in events_due, oldest first.
  // ---------------------------------------------------------------------------
  logic [31:0] ring_keys [RING_SLOTS];
  int          ring_rd;
  int          ring_wr;
  bit          fetch_pending;   // a fetch is outstanding or the ring is being walked
  bit          walk_paused;     // the walk hit the per-transaction result budget
  logic        slot_sel;        // slot that the next fetch request goes to
  logic [9:0]  slot_words [2];  // payload words of the row fetched into each slot
  skrf_entry_t route_table [TABLE_ENTRIES];
  logic [15:0] ovf_count;

  skrf_out_t step_events [$];
  skrf_out_t events_due [$];

  // Builds one result. Only fetch requests and ready rows carry a length and a word count;
  // every result carries the overflow counter as it stands when the result is made.
  function automatic skrf_out_t make_event(logic [1:0] kind, logic slot, logic [31:0] addr,
                                           logic [9:0] words, logic [31:0] dkey);
    skrf_out_t ev;
    ev = '0;
    ev.kind = kind;
    ev.slot = slot;
    ev.row_address = addr;
    if (kind == KIND_FETCH || kind == KIND_READY) begin
      ev.row_words = words;
      ev.length_bytes = ({3'd0, words} + 13'd3) << 2;
    end
    ev.dropped_key = dkey;
    ev.overflow_count = ovf_count;
    return ev;
  endfunction

  // Pops keys and matches each against the table in order. The walk over the table stops
  // at the first id of all ones. The first hit issues a fetch and ends the walk over the
  // ring; keys that hit nothing are reported as dropped. A full result budget pauses the walk,
  // and an empty ring makes the sequencer idle again.
  function automatic void walk_ring();
    logic [31:0] k;
    logic [31:0] stride;
    int i;
    while (ring_rd != ring_wr) begin
      if (step_events.size() >= MAX_RESULTS) begin
        walk_paused = 1'b1;
        return;
      end
      k = ring_keys[ring_rd];
      ring_rd = (ring_rd + 1) % RING_SLOTS;
      for (i = 0; i < TABLE_ENTRIES && route_table[i].id != ID_END; i++) begin
        if ((route_table[i].mask & k) == route_table[i].id) begin
          // Each row is its payload plus a three-word header; the address wraps at 32 bits.
          stride = {22'd0, route_table[i].row_words} * 32'd4 + 32'd12;
          slot_words[slot_sel] = route_table[i].row_words;
          step_events.push_back(make_event(KIND_FETCH, slot_sel,
                                           route_table[i].base + (k & ~route_table[i].mask) * stride,
                                           route_table[i].row_words, 32'd0));
          slot_sel = ~slot_sel;
          walk_paused = 1'b0;
          return;
        end
      end
      step_events.push_back(make_event(KIND_DROP, 1'b0, 32'd0, 10'd0, k));
    end
    fetch_pending = 1'b0;
    walk_paused = 1'b0;
  endfunction

  function automatic void step_sequencer(skrf_in_t it);
    int nxt;
    logic done_slot;
    skrf_out_t tail;
    step_events.delete();
    case (it.cmd)
      CMD_LOAD: begin
        if (it.entry_index < TABLE_ENTRIES) begin
          route_table[it.entry_index].mask = it.entry_mask;
          route_table[it.entry_index].id = it.entry_id;
          route_table[it.entry_index].base = it.entry_base;
          route_table[it.entry_index].row_words = it.entry_row_words;
        end
      end
      CMD_KEY: begin
        nxt = (ring_wr + 1) % RING_SLOTS;
        if (nxt == ring_rd) begin
          // One slot of the ring always stays empty, so a full ring loses the key.
          if (ovf_count != OVF_MAX) ovf_count++;
          step_events.push_back(make_event(KIND_OVF, 1'b0, 32'd0, 10'd0, it.key));
        end else begin
          ring_keys[ring_wr] = it.key;
          ring_wr = nxt;
          if (!fetch_pending) begin
            fetch_pending = 1'b1;
            walk_ring();
          end else if (walk_paused) begin
            walk_ring();
          end
        end
      end
      CMD_DONE: begin
        // A row done with nothing outstanding is a stray and is dropped silently.
        if (fetch_pending && walk_paused) begin
          walk_ring();
        end else if (fetch_pending) begin
          done_slot = ~slot_sel;
          step_events.push_back(make_event(KIND_READY, done_slot, 32'd0,
                                           slot_words[done_slot], 32'd0));
          walk_ring();
        end
      end
      default: ;
    endcase
    if (step_events.size() > 0) begin
      tail = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
  endfunction

  // A single result whose fields can be written down directly: a dropped or lost key.
  function automatic skrf_out_t fixed_event(logic [1:0] kind, logic [31:0] dkey,
                                            logic [15:0] count);
    skrf_out_t ev;
    ev = '0;
    ev.kind = kind;
    ev.dropped_key = dkey;
    ev.overflow_count = count;
    ev.last = 1'b1;
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields that a command does not use get random values so
  // that their bits still toggle on the port.
  // ---------------------------------------------------------------------------
  function automatic skrf_in_t make_item(logic [1:0] cmd);
    skrf_in_t it;
    it.cmd = cmd;
    it.key = $urandom;
    it.entry_index = 4'($urandom);
    it.entry_mask = $urandom;
    it.entry_id = $urandom;
    it.entry_base = $urandom;
    it.entry_row_words = 10'($urandom);
    return it;
  endfunction

  function automatic skrf_in_t load_item(logic [3:0] idx, logic [31:0] mask, logic [31:0] id,
                                         logic [31:0] base, logic [9:0] words);
    skrf_in_t it;
    it = make_item(CMD_LOAD);
    it.entry_index = idx;
    it.entry_mask = mask;
    it.entry_id = id;
    it.entry_base = base;
    it.entry_row_words = words;
    return it;
  endfunction

  function automatic skrf_in_t key_item(logic [31:0] k);
    skrf_in_t it;
    it = make_item(CMD_KEY);
    it.key = k;
    return it;
  endfunction

  // A key built to hit a randomly chosen table entry, unless an earlier entry catches it
  // first or the entry's id has bits outside its mask.
  function automatic logic [31:0] table_key();
    skrf_entry_t e;
    e = route_table[$urandom_range(0, TABLE_ENTRIES - 1)];
    return (e.id & e.mask) | ($urandom & ~e.mask);
  endfunction

  // One row of the directed table: a transaction, how many times to send it, and, where
  // the answer is obvious, the single result (or the absence of one) typed in by hand.
  typedef struct {
    skrf_in_t  item;
    int        copies;
    bit        typed;
    bit        has_result;
    skrf_out_t result;
  } plan_row_t;

  function automatic plan_row_t plan_step(skrf_in_t it, int copies, bit typed, bit has_result,
                                          skrf_out_t result);
    plan_row_t p;
    p.item = it;
    p.copies = copies;
    p.typed = typed;
    p.has_result = has_result;
    p.result = result;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int n_loads    = 0;
  int n_keys     = 0;
  int n_dones    = 0;
  int n_unused   = 0;

  // Holds the transaction on the port until it is taken, then steps the model at that
  // edge. A typed row replaces the model's answer with the one written in the table.
  task automatic send_item(input skrf_in_t item, input bit typed, input bit typed_has,
                           input skrf_out_t typed_ev);
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_sequencer(item);
    if (typed) begin
      if (typed_has) events_due.push_back(typed_ev);
    end else begin
      foreach (step_events[j]) events_due.push_back(step_events[j]);
    end
    case (item.cmd)
      CMD_LOAD: n_loads++;
      CMD_KEY:  n_keys++;
      CMD_DONE: n_dones++;
      default:  n_unused++;
    endcase
  endtask

  // Bursts of random length separated by short idle gaps; now and then a long burst so
  // that back-to-back transactions get exercised as well.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  // Drops valid and waits for every owed result. At least one edge passes, so valid is
  // never lowered and raised again at the same edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern and result checking.
  // ---------------------------------------------------------------------------
  int        cycle_count     = 0;
  int        mismatches      = 0;
  int        results_checked = 0;
  int        overflows_seen  = 0;
  skrf_out_t head_event;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s differs, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        report_mismatch("result with nothing owed, kind", out_data.kind, 32'd0);
      end else begin
        head_event = events_due.pop_front();
        if (out_data.kind !== head_event.kind)
          report_mismatch("kind", out_data.kind, head_event.kind);
        if (out_data.slot !== head_event.slot)
          report_mismatch("slot", out_data.slot, head_event.slot);
        if (out_data.row_address !== head_event.row_address)
          report_mismatch("row_address", out_data.row_address, head_event.row_address);
        if (out_data.length_bytes !== head_event.length_bytes)
          report_mismatch("length_bytes", out_data.length_bytes, head_event.length_bytes);
        if (out_data.row_words !== head_event.row_words)
          report_mismatch("row_words", out_data.row_words, head_event.row_words);
        if (out_data.dropped_key !== head_event.dropped_key)
          report_mismatch("dropped_key", out_data.dropped_key, head_event.dropped_key);
        if (out_data.overflow_count !== head_event.overflow_count)
          report_mismatch("overflow_count", out_data.overflow_count, head_event.overflow_count);
        if (out_data.last !== head_event.last)
          report_mismatch("last", out_data.last, head_event.last);
        results_checked++;
        if (head_event.kind == KIND_OVF) overflows_seen++;
      end
    end
    // The receiver cycles through four moods: always ready, mostly ready, a fixed
    // two-in-eight stall, and mostly stalled, in turn, chosen by bits 8:7 of the cycle count.
    case (cycle_count[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[2:0] != 3'd6);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // A hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at cycle %0d with %0d results still owed", cycle_count,
             events_due.size());
    $display("spike_key_row_fetch_sequencer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   directed_plan [$];
    skrf_in_t    it;
    logic [31:0] mask;
    logic [31:0] id;
    int          counted;
    int          flood_left;
    int          r;
    bit          drained_once;
    bit          flooded;
    bit          ignored;

    // Model state after reset: empty ring, idle sequencer, table of end markers.
    ring_rd = 0;
    ring_wr = 0;
    fetch_pending = 1'b0;
    walk_paused = 1'b0;
    slot_sel = 1'b0;
    slot_words[0] = '0;
    slot_words[1] = '0;
    ovf_count = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) route_table[i] = {32'd0, ID_END, 32'd0, 10'd0};

    // Directed table. The entry at index 1 starts out as an end marker, so a key that
    // misses entry 0 must not reach the catch-all entry loaded behind it.
    directed_plan.push_back(plan_step(make_item(CMD_DONE), 1, 1'b1, 1'b0, '0));   // stray done
    directed_plan.push_back(plan_step(make_item(CMD_UNUSED), 1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'h0000_0000), 1, 1'b1, 1'b1,
                                      fixed_event(KIND_DROP, 32'h0000_0000, 16'd0)));
    directed_plan.push_back(plan_step(key_item(32'hFFFF_FFFF), 1, 1'b1, 1'b1,
                                      fixed_event(KIND_DROP, 32'hFFFF_FFFF, 16'd0)));
    directed_plan.push_back(plan_step(load_item(4'd0, 32'hFFFF_0000, 32'h1234_0000,
                                                 32'h1000_0000, 10'd0), 1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(load_item(4'd1, 32'hFFFF_FFFF, ID_END, 32'hFFFF_FFFF,
                                                10'h3FF), 1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(load_item(4'd2, 32'd0, 32'd0, 32'hFFFF_FFF0, 10'h3FF),
                                      1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(load_item(4'd15, 32'd0, 32'd0, 32'd0, 10'd0),
                                      1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'hDEAD_BEEF), 1, 1'b1, 1'b1,
                                      fixed_event(KIND_DROP, 32'hDEAD_BEEF, 16'd0)));
    // First fetch; the keys behind it fill the ring, the next one is lost, and the row
    // done then drains the whole ring in one go (the largest result burst).
    directed_plan.push_back(plan_step(key_item(32'h1234_0005), 1, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'hDEAD_BEEF), RING_SLOTS - 1, 1'b1, 1'b0,
                                      '0));
    directed_plan.push_back(plan_step(key_item(32'h0000_0001), 1, 1'b1, 1'b1,
                                      fixed_event(KIND_OVF, 32'h0000_0001, 16'd1)));
    directed_plan.push_back(plan_step(make_item(CMD_DONE), 1, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step(make_item(CMD_DONE), 1, 1'b1, 1'b0, '0));
    // Second entry in place of the end marker; address arithmetic wraps here.
    directed_plan.push_back(plan_step(load_item(4'd1, 32'h0000_FFFF, 32'h0000_ABCD, 32'd0,
                                                10'd1), 1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'hFFFF_ABCD), 1, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'h1234_FFFF), 2, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step(make_item(CMD_DONE), 3, 1'b0, 1'b0, '0));
    // Largest row from the top of the address space.
    directed_plan.push_back(plan_step(load_item(4'd1, 32'd0, 32'd0, 32'hFFFF_FFF0, 10'h3FF),
                                      1, 1'b1, 1'b0, '0));
    directed_plan.push_back(plan_step(key_item(32'hFFFF_FFFF), 1, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step(make_item(CMD_DONE), 1, 1'b0, 1'b0, '0));
    directed_plan.push_back(plan_step('1, 1, 1'b1, 1'b0, '0));   // unused command, all ones
    directed_plan.push_back(plan_step('0, 1, 1'b1, 1'b0, '0));   // catch-all at entry 0

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[p]) begin
      repeat (directed_plan[p].copies) begin
        send_item(directed_plan[p].item, directed_plan[p].typed, directed_plan[p].has_result,
                  directed_plan[p].result);
        pace_sender();
      end
    end

    // Random traffic. Most keys are built to hit the table; floods of keys with no row
    // done fill the ring again. Ignored transactions do not count toward the total.
    counted = 0;
    flood_left = 0;
    drained_once = 1'b0;
    flooded = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (!drained_once && counted >= RANDOM_ITEMS / 3) begin
        wait_drained();
        drained_once = 1'b1;
      end
      if (!flooded && counted >= RANDOM_ITEMS / 2) begin
        flood_left = RING_SLOTS + 4;
        flooded = 1'b1;
      end else if (flood_left == 0 && $urandom_range(0, 79) == 0) begin
        flood_left = RING_SLOTS + 4;
      end

      r = $urandom_range(0, 99);
      if (flood_left > 0) begin
        it = key_item(table_key());
        flood_left--;
      end else if (r < 12) begin
        case ($urandom_range(0, 3))
          0:       mask = $urandom;
          1:       mask = 32'd0;
          default: mask = 32'hFFFF_FFFF << $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 9))
          0:       id = ID_END;
          1:       id = $urandom;
          default: id = $urandom & mask;
        endcase
        it = load_item(4'($urandom_range(0, TABLE_ENTRIES - 1)), mask, id, $urandom,
                       10'($urandom_range(0, 1023)));
      end else if (r < 62) begin
        it = key_item(($urandom_range(0, 9) < 7) ? table_key() : $urandom);
      end else if (r < 95) begin
        it = make_item(CMD_DONE);
      end else begin
        it = make_item(CMD_UNUSED);
      end

      ignored = (it.cmd == CMD_UNUSED) || (it.cmd == CMD_DONE && !fetch_pending);
      send_item(it, 1'b0, 1'b0, '0);
      if (!ignored) counted++;
      pace_sender();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d transactions: %0d table loads, %0d keys, %0d row done, %0d unused",
             n_loads + n_keys + n_dones + n_unused, n_loads, n_keys, n_dones, n_unused);
    $display("checked %0d results, %0d of them ring overflows", results_checked,
             overflows_seen);
    if (mismatches == 0) begin
      $display("spike_key_row_fetch_sequencer: match");
    end else begin
      $display("spike_key_row_fetch_sequencer: mismatch");
    end
    $finish;
  end

endmodule
